// ----- rtl/dshv_pkg.sv -----
`timescale 1ns / 1ps

package dshv_pkg;

  localparam int unsigned HEADER_BYTES = 28;
  localparam int unsigned IDX_W        = 5;
  localparam logic [7:0]  MAX_FORMAT   = 8'd13;
  localparam logic [3:0]  TABLE_TOP    = 4'd13;

  localparam logic [31:0] MAGIC_WORD   = 32'h5453_544E;
  localparam logic [31:0] COMMIT_WORD  = 32'h434F_4D4D;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

  // byte offsets at which a header field completes
  localparam logic [IDX_W-1:0] IDX_MAGIC  = 5'd3;
  localparam logic [IDX_W-1:0] IDX_VER    = 5'd5;
  localparam logic [IDX_W-1:0] IDX_HSIZE  = 5'd7;
  localparam logic [IDX_W-1:0] IDX_SEQ    = 5'd11;
  localparam logic [IDX_W-1:0] IDX_LEN    = 5'd15;
  localparam logic [IDX_W-1:0] IDX_PCRC   = 5'd19;
  localparam logic [IDX_W-1:0] IDX_HCRC   = 5'd23;
  localparam logic [IDX_W-1:0] IDX_COMMIT = 5'd27;
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] CRC_BYTES  = 5'd20;

  typedef struct packed {
    logic        done;
    logic        slot;
    logic        ok;
    logic [31:0] seq;
    logic [3:0]  ver;
    logic [31:0] len;
    logic [31:0] pcrc;
  } hdr_done_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [8:0] len_for_ver(input logic [3:0] v);
    logic [8:0] n;
    case (v)
      4'd1:    n = 9'd36;
      4'd2:    n = 9'd64;
      4'd3:    n = 9'd104;
      4'd4:    n = 9'd168;
      4'd5:    n = 9'd184;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd204;
      4'd8:    n = 9'd256;
      4'd9:    n = 9'd292;
      4'd10:   n = 9'd344;
      4'd11:   n = 9'd348;
      4'd12:   n = 9'd448;
      4'd13:   n = 9'd472;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/dshv_hdr.sv -----
`timescale 1ns / 1ps

module dshv_hdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_slot,
  input  logic [7:0]          in_header_byte,
  input  logic                in_read_error,
  input  logic                hold_last,
  output dshv_pkg::hdr_done_t hdr
);

  logic [dshv_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic        ver_tab_r, ver_tab_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic        pass_r, pass_nxt;
  logic        last;
  logic        accept;
  logic [15:0] hi_half;

  assign last     = (idx_r == dshv_pkg::IDX_LAST);
  // the final word needs the result register free
  assign in_stall = hold_last && last;
  assign accept   = in_valid && !in_stall;
  assign acc_nxt  = {in_header_byte, acc_r[31:8]};
  assign hi_half  = acc_nxt[31:16];

  always_comb begin
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    ver_nxt     = ver_r;
    ver_tab_nxt = ver_tab_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    pcrc_nxt    = pcrc_r;
    pass_nxt    = pass_r;
    if (in_read_error) begin
      pass_nxt = 1'b0;
    end
    if (idx_r < dshv_pkg::CRC_BYTES) begin
      crc_nxt = dshv_pkg::crc_byte(crc_r, in_header_byte);
    end
    case (idx_r)
      dshv_pkg::IDX_MAGIC: begin
        if (acc_nxt != dshv_pkg::MAGIC_WORD) pass_nxt = 1'b0;
      end
      dshv_pkg::IDX_VER: begin
        ver_nxt     = hi_half[3:0];
        ver_tab_nxt = (hi_half != 16'd0) && (hi_half <= {12'd0, dshv_pkg::TABLE_TOP});
        if (hi_half == 16'd0 || hi_half > {8'd0, dshv_pkg::MAX_FORMAT}) pass_nxt = 1'b0;
      end
      dshv_pkg::IDX_HSIZE: begin
        if (hi_half != 16'(dshv_pkg::HEADER_BYTES)) pass_nxt = 1'b0;
      end
      dshv_pkg::IDX_SEQ:  seq_nxt  = acc_nxt;
      dshv_pkg::IDX_LEN:  len_nxt  = acc_nxt;
      dshv_pkg::IDX_PCRC: pcrc_nxt = acc_nxt;
      dshv_pkg::IDX_HCRC: begin
        if (acc_nxt != ~crc_r) pass_nxt = 1'b0;
      end
      dshv_pkg::IDX_COMMIT: begin
        if (acc_nxt != dshv_pkg::COMMIT_WORD) pass_nxt = 1'b0;
      end
      default: ;
    endcase
    if (last) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    hdr.done = accept && last;
    hdr.slot = in_slot;
    hdr.ok   = pass_nxt && ver_tab_r && (len_r == {23'd0, dshv_pkg::len_for_ver(ver_r)});
    hdr.seq  = seq_r;
    hdr.ver  = ver_r;
    hdr.len  = len_r;
    hdr.pcrc = pcrc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      crc_r  <= dshv_pkg::CRC_INIT;
      pass_r <= 1'b1;
    end else if (accept) begin
      if (last) begin
        // drop the finished header, start over
        idx_r  <= '0;
        crc_r  <= dshv_pkg::CRC_INIT;
        pass_r <= 1'b1;
      end else begin
        idx_r  <= idx_nxt;
        crc_r  <= crc_nxt;
        pass_r <= pass_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r     <= acc_nxt;
      ver_r     <= ver_nxt;
      ver_tab_r <= ver_tab_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      pcrc_r    <= pcrc_nxt;
    end
  end

endmodule

// ----- rtl/dshv_slot.sv -----
`timescale 1ns / 1ps

module dshv_slot (
  input  logic                clk,
  input  logic                rst_n,
  input  dshv_pkg::hdr_done_t hdr,
  output logic                hold_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_slot_id,
  output logic                out_slot_ok,
  output logic [31:0]         out_seq_number,
  output logic [3:0]          out_format_ver,
  output logic [31:0]         out_body_length,
  output logic [31:0]         out_body_crc,
  output logic                out_load_first,
  output logic                out_any_loadable,
  output logic                out_store_target,
  output logic [31:0]         out_store_seq
);

  logic [1:0]  vld_r, vld_nxt;
  logic [31:0] sq_r [2];
  logic [31:0] sq_nxt [2];
  logic        first, target;
  logic [31:0] sseq;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_r, ok_r, first_r, any_r, target_r;
  logic [31:0] seq_r, len_r, pcrc_r, sseq_r;
  logic [3:0]  ver_r;

  always_comb begin
    vld_nxt   = vld_r;
    sq_nxt[0] = sq_r[0];
    sq_nxt[1] = sq_r[1];
    if (hdr.done) begin
      vld_nxt[hdr.slot] = hdr.ok;
      sq_nxt[hdr.slot]  = hdr.ok ? hdr.seq : 32'd0;
    end
  end

  // equal sequences: load slot 0, overwrite slot 0
  always_comb begin
    first = vld_nxt[1] && (!vld_nxt[0] || (sq_nxt[1] > sq_nxt[0]));
    if (!vld_nxt[0]) begin
      target = 1'b0;
      sseq   = 32'd1;
    end else if (!vld_nxt[1]) begin
      target = 1'b1;
      sseq   = sq_nxt[0] + 32'd1;
    end else if (sq_nxt[0] <= sq_nxt[1]) begin
      target = 1'b0;
      sseq   = sq_nxt[1] + 32'd1;
    end else begin
      target = 1'b1;
      sseq   = sq_nxt[0] + 32'd1;
    end
  end

  assign hold_last     = out_valid_r && out_stall;
  assign out_valid_nxt = hdr.done || hold_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.done) begin
      sq_r[0]  <= sq_nxt[0];
      sq_r[1]  <= sq_nxt[1];
      slot_r   <= hdr.slot;
      ok_r     <= hdr.ok;
      seq_r    <= hdr.ok ? hdr.seq : 32'd0;
      ver_r    <= hdr.ok ? hdr.ver : 4'd0;
      len_r    <= hdr.ok ? hdr.len : 32'd0;
      pcrc_r   <= hdr.ok ? hdr.pcrc : 32'd0;
      first_r  <= first;
      any_r    <= vld_nxt[0] || vld_nxt[1];
      target_r <= target;
      sseq_r   <= sseq;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_id      = slot_r;
  assign out_slot_ok      = ok_r;
  assign out_seq_number   = seq_r;
  assign out_format_ver   = ver_r;
  assign out_body_length  = len_r;
  assign out_body_crc     = pcrc_r;
  assign out_load_first   = first_r;
  assign out_any_loadable = any_r;
  assign out_store_target = target_r;
  assign out_store_seq    = sseq_r;

endmodule

// ----- rtl/dual_slot_header_validator.sv -----
`timescale 1ns / 1ps
// The result word is registered and valid in the cycle after byte 27 of a header is taken.
// The input takes one header byte per cycle while in_stall is low.
// The input stalls only on byte 27 while the previous result is still held;
// every other byte is taken regardless of the output side.
// Reset (rst_n low, synchronous): byte count cleared, both slots invalid, no result.

module dual_slot_header_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_slot,
  input  logic [7:0]  in_header_byte,
  input  logic        in_read_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_slot_id,
  output logic        out_slot_ok,
  output logic [31:0] out_seq_number,
  output logic [3:0]  out_format_ver,
  output logic [31:0] out_body_length,
  output logic [31:0] out_body_crc,
  output logic        out_load_first,
  output logic        out_any_loadable,
  output logic        out_store_target,
  output logic [31:0] out_store_seq
);

  dshv_pkg::hdr_done_t hdr;
  logic                hold_last;

  dshv_hdr u_hdr (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_slot        (in_slot),
    .in_header_byte (in_header_byte),
    .in_read_error  (in_read_error),
    .hold_last      (hold_last),
    .hdr            (hdr)
  );

  dshv_slot u_slot (
    .clk              (clk),
    .rst_n            (rst_n),
    .hdr              (hdr),
    .hold_last        (hold_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_id      (out_slot_id),
    .out_slot_ok      (out_slot_ok),
    .out_seq_number   (out_seq_number),
    .out_format_ver   (out_format_ver),
    .out_body_length  (out_body_length),
    .out_body_crc     (out_body_crc),
    .out_load_first   (out_load_first),
    .out_any_loadable (out_any_loadable),
    .out_store_target (out_store_target),
    .out_store_seq    (out_store_seq)
  );

endmodule

// ----- dv/tb_dual_slot_header_validator.sv -----
`timescale 1ns / 1ps

module tb_dual_slot_header_validator;

  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam bit [31:0] BODY_LEN_BY_VER [0:13] = '{
    32'd0, 32'd36, 32'd64, 32'd104, 32'd168, 32'd184, 32'd184,
    32'd204, 32'd256, 32'd292, 32'd344, 32'd348, 32'd448, 32'd472
  };

  typedef enum int {
    FLAW_NONE, FLAW_SLOT_MIX, FLAW_MAGIC, FLAW_HSIZE, FLAW_HCRC,
    FLAW_COMMIT, FLAW_LEN, FLAW_READ_ERR
  } flaw_t;

  typedef struct {
    bit        slot;
    bit        ok;
    bit [31:0] seq;
    bit [3:0]  ver;
    bit [31:0] len;
    bit [31:0] pcrc;
    bit        load_sel;
    bit        any_ok;
    bit        target;
    bit [31:0] next_seq;
  } slot_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_slot = 1'b0;
  logic [7:0]  in_header_byte = 8'd0;
  logic        in_read_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_slot_id;
  logic        out_slot_ok;
  logic [31:0] out_seq_number;
  logic [3:0]  out_format_ver;
  logic [31:0] out_body_length;
  logic [31:0] out_body_crc;
  logic        out_load_first;
  logic        out_any_loadable;
  logic        out_store_target;
  logic [31:0] out_store_seq;

  dual_slot_header_validator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // header parser state and slot table, as the block should hold them
  bit [4:0]  hb_idx = '0;
  bit [31:0] hb_crc = 32'hFFFF_FFFF;
  bit [31:0] hb_word = '0;
  bit [15:0] hb_ver = '0;
  bit [31:0] hb_seq = '0;
  bit [31:0] hb_len = '0;
  bit [31:0] hb_pcrc = '0;
  bit        hb_good = 1'b1;
  bit        slot_valid [2] = '{1'b0, 1'b0};
  bit [31:0] slot_seq [2] = '{32'd0, 32'd0};

  slot_verdict_t verdict_q[$];

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned results_ok = 0;
  int unsigned held_cycles = 0;
  int unsigned cycles = 0;
  bit          in_gap_on = 1'b1;

  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;

  function automatic bit [31:0] crc_advance(input bit [31:0] c, input bit [7:0] b);
    bit [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    return r;
  endfunction

  task automatic predict_byte(input bit s, input bit [7:0] b, input bit err);
    slot_verdict_t v;
    bit ok;
    if (err) hb_good = 1'b0;
    if (hb_idx < dshv_pkg::CRC_BYTES) hb_crc = crc_advance(hb_crc, b);
    hb_word = {b, hb_word[31:8]};
    case (hb_idx)
      dshv_pkg::IDX_MAGIC:  if (hb_word != dshv_pkg::MAGIC_WORD) hb_good = 1'b0;
      dshv_pkg::IDX_VER: begin
        hb_ver = hb_word[31:16];
        if (hb_ver < 16'd1 || hb_ver > 16'd13) hb_good = 1'b0;
      end
      dshv_pkg::IDX_HSIZE:  if (hb_word[31:16] != 16'd28) hb_good = 1'b0;
      dshv_pkg::IDX_SEQ:    hb_seq = hb_word;
      dshv_pkg::IDX_LEN:    hb_len = hb_word;
      dshv_pkg::IDX_PCRC:   hb_pcrc = hb_word;
      dshv_pkg::IDX_HCRC:   if (hb_word != ~hb_crc) hb_good = 1'b0;
      dshv_pkg::IDX_COMMIT: if (hb_word != dshv_pkg::COMMIT_WORD) hb_good = 1'b0;
      default: ;
    endcase
    if (hb_idx != dshv_pkg::IDX_LAST) begin
      hb_idx++;
      return;
    end
    ok = hb_good && hb_ver >= 16'd1 && hb_ver <= 16'd13 &&
         BODY_LEN_BY_VER[hb_ver[3:0]] == hb_len;
    slot_valid[s] = ok;
    slot_seq[s] = ok ? hb_seq : 32'd0;
    v.slot = s;
    v.ok = ok;
    v.seq = ok ? hb_seq : 32'd0;
    v.ver = ok ? hb_ver[3:0] : 4'd0;
    v.len = ok ? hb_len : 32'd0;
    v.pcrc = ok ? hb_pcrc : 32'd0;
    v.load_sel = slot_valid[1] && (!slot_valid[0] || slot_seq[1] > slot_seq[0]);
    v.any_ok = slot_valid[0] || slot_valid[1];
    if (!slot_valid[0]) begin
      v.target = 1'b0;
      v.next_seq = 32'd1;
    end else if (!slot_valid[1]) begin
      v.target = 1'b1;
      v.next_seq = slot_seq[0] + 32'd1;
    end else if (slot_seq[0] <= slot_seq[1]) begin
      v.target = 1'b0;
      v.next_seq = slot_seq[1] + 32'd1;
    end else begin
      v.target = 1'b1;
      v.next_seq = slot_seq[0] + 32'd1;
    end
    verdict_q.push_back(v);
    hb_idx = '0;
    hb_crc = 32'hFFFF_FFFF;
    hb_word = '0;
    hb_ver = '0;
    hb_seq = '0;
    hb_len = '0;
    hb_pcrc = '0;
    hb_good = 1'b1;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!in_gap_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_byte(input bit s, input bit [7:0] b, input bit err);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_slot <= s;
    in_header_byte <= b;
    in_read_error <= err;
    @(posedge clk);
    while (in_stall) begin
      held_cycles++;
      @(posedge clk);
    end
    predict_byte(s, b, err);
    bytes_sent++;
  endtask

  task automatic send_header(input bit s, input bit [15:0] ver, input bit [31:0] seq,
                             input bit [31:0] len, input bit [31:0] pcrc, input flaw_t flaw);
    bit [223:0] img;
    bit [31:0]  c;
    bit [15:0]  hsize;
    int         err_at;
    int         bit_at;
    bit         bs;
    // realign the byte counter with random filler
    while (hb_idx != 0)
      send_byte(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
    hsize = 16'd28;
    err_at = -1;
    bit_at = $urandom_range(31);
    img = '0;
    img[31:0] = dshv_pkg::MAGIC_WORD;
    img[47:32] = ver;
    img[95:64] = seq;
    img[127:96] = len;
    img[159:128] = pcrc;
    img[223:192] = dshv_pkg::COMMIT_WORD;
    case (flaw)
      FLAW_MAGIC:    img[bit_at] = ~img[bit_at];
      FLAW_HSIZE:    hsize[bit_at % 16] = ~hsize[bit_at % 16];
      FLAW_COMMIT:   img[192 + bit_at] = ~img[192 + bit_at];
      FLAW_LEN:      img[96 + bit_at] = ~img[96 + bit_at];
      FLAW_READ_ERR: err_at = $urandom_range(27);
      default: ;
    endcase
    img[63:48] = hsize;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < 20; i++) c = crc_advance(c, img[8*i +: 8]);
    img[191:160] = ~c;
    if (flaw == FLAW_HCRC) img[160 + bit_at] = ~img[160 + bit_at];
    for (int i = 0; i < 28; i++) begin
      bs = (flaw == FLAW_SLOT_MIX && i != 27) ? bit'($urandom_range(1)) : s;
      send_byte(bs, img[8*i +: 8], i == err_at);
    end
  endtask

  task automatic send_good(input bit s, input bit [3:0] ver, input bit [31:0] seq);
    send_header(s, {12'd0, ver}, seq, BODY_LEN_BY_VER[ver], $urandom, FLAW_NONE);
  endtask

  task automatic check_field(input string name, input bit [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    slot_verdict_t v;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("result word with no header pending");
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (v.ok) results_ok++;
        check_field("slot_id", 32'(v.slot), 32'(out_slot_id));
        check_field("slot_ok", 32'(v.ok), 32'(out_slot_ok));
        check_field("seq_number", v.seq, out_seq_number);
        check_field("format_ver", 32'(v.ver), 32'(out_format_ver));
        check_field("body_length", v.len, out_body_length);
        check_field("body_crc", v.pcrc, out_body_crc);
        check_field("load_first", 32'(v.load_sel), 32'(out_load_first));
        check_field("any_loadable", 32'(v.any_ok), 32'(out_any_loadable));
        check_field("store_target", 32'(v.target), 32'(out_store_target));
        check_field("store_seq", v.next_seq, out_store_seq);
      end
    end
  end

  // output back-pressure: random bursts, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
      run_left <= 0;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      run_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
      run_left <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_good_headers();
    send_good(1'b0, 4'd1, 32'd5);
    send_good(1'b1, 4'd13, 32'h0000_0000);
    send_good(1'b1, 4'd7, 32'hFFFF_FFFF);
    send_header(1'b0, 16'd6, 32'h8000_0001, 32'd184, 32'hFFFF_FFFF, FLAW_SLOT_MIX);
  endtask

  task automatic test_header_defects();
    send_header(1'b0, 16'd2, 32'd10, 32'd64, 32'd0, FLAW_MAGIC);
    send_header(1'b1, 16'd0, 32'd11, 32'd0, 32'd0, FLAW_NONE);
    send_header(1'b1, 16'd14, 32'd12, 32'd472, 32'd0, FLAW_NONE);
    send_header(1'b0, 16'hFFFF, 32'd13, 32'd36, 32'd0, FLAW_NONE);
    send_header(1'b0, 16'd3, 32'd14, 32'd104, 32'd0, FLAW_HSIZE);
    send_header(1'b1, 16'd4, 32'd15, 32'd168, 32'd0, FLAW_HCRC);
    send_header(1'b0, 16'd8, 32'd16, 32'd256, 32'd0, FLAW_COMMIT);
    send_header(1'b1, 16'd9, 32'd17, 32'd292, 32'd0, FLAW_LEN);
    send_header(1'b0, 16'd10, 32'd18, 32'd344, 32'd0, FLAW_READ_ERR);
    // stray bytes leave the counter misaligned; the next header realigns
    send_byte(1'b1, 8'hFF, 1'b1);
    send_byte(1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_slot_order();
    send_good(1'b0, 4'd11, 32'd100);
    send_good(1'b1, 4'd12, 32'd100);
    send_good(1'b1, 4'd5, 32'd200);
    send_good(1'b0, 4'd2, 32'hFFFF_FFFF);
    send_header(1'b0, 16'd2, 32'd1, 32'd64, 32'd0, FLAW_READ_ERR);
  endtask

  task automatic test_output_hold_off();
    stall_pct <= 0;
    in_gap_on = 1'b0;
    hold_req <= hold_req + 1;
    repeat (4) send_good(1'($urandom_range(1)), 4'($urandom_range(1, 13)), $urandom);
    in_gap_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned r;
    bit          s;
    bit [15:0]   ver;
    bit [31:0]   seq;
    flaw_t       flaw;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(7) == 0) begin
        in_gap_on = $urandom_range(3) != 0;
        r = $urandom_range(2);
        stall_pct <= (r == 0) ? 0 : (r == 1) ? 20 : 60;
      end
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 35))
          send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(15) == 0);
      end else begin
        s = 1'($urandom_range(1));
        r = $urandom_range(9);
        ver = (r == 0) ? 16'($urandom) : 16'($urandom_range(1, 13));
        r = $urandom_range(99);
        if (r < 40)      seq = $urandom;
        else if (r < 55) seq = 32'hFFFF_FFFF - $urandom_range(3);
        else if (r < 70) seq = $urandom_range(3);
        else if (r < 90) seq = slot_seq[~s] + $urandom_range(2) - 1;
        else             seq = 32'd0;
        r = $urandom_range(99);
        if (r < 65)      flaw = FLAW_NONE;
        else if (r < 72) flaw = FLAW_SLOT_MIX;
        else             flaw = flaw_t'($urandom_range(FLAW_MAGIC, FLAW_READ_ERR));
        send_header(s, ver, seq, (ver <= 16'd13) ? BODY_LEN_BY_VER[ver[3:0]] : $urandom,
                    $urandom, flaw);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_good_headers();
    test_header_defects();
    stall_pct <= 30;
    test_slot_order();
    test_output_hold_off();
    test_random_traffic();
    in_valid <= 1'b0;
    stall_pct <= 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d header bytes; checked %0d results (%0d valid, %0d rejected).",
             bytes_sent, results_seen, results_ok, results_seen - results_ok);
    $display("Input held off for %0d cycles under output back-pressure.", held_cycles);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dshv_pkg.sv
rtl/dshv_hdr.sv
rtl/dshv_slot.sv
rtl/dual_slot_header_validator.sv
dv/tb_dual_slot_header_validator.sv
